// ===== hw/rtl/tcac_pkg.sv =====
`default_nettype none

package tcac_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int POS_W      = $clog2(CELL_COUNT);
    localparam int SUM_W      = POS_W + 1;
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int CHAR_W     = 8;
    localparam int ATTR_W     = 8;
    localparam int CELL_W     = CHAR_W + ATTR_W;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [ATTR_W-1:0] GREEN_ATTR = 8'h0A;
    localparam logic [ATTR_W-1:0] WHITE_ATTR = 8'h0F;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;

    // work code handed from the front to the back
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    typedef struct packed {
        logic [1:0]        kind;
        logic              scroll;
        logic [POS_W-1:0]  addr;
        logic [CHAR_W-1:0] chr;
        logic [ATTR_W-1:0] color;
        logic [POS_W-1:0]  cursor;
    } t_cmd;

endpackage

`default_nettype wire

// ===== hw/rtl/tcac_front.sv =====
`default_nettype none

module tcac_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [1:0]                    i_opcode,
    input  wire logic [tcac_pkg::CHAR_W-1:0]   i_char_code,
    input  wire logic [tcac_pkg::POS_W-1:0]    i_cell_address,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [tcac_pkg::POS_W-1:0]    i_cfg_wr_data,
    input  wire logic                          i_full,
    output logic                               o_push,
    output tcac_pkg::t_cmd                     o_push_cmd
);

    localparam logic [2:0] ESC_IDLE    = 3'd0;
    localparam logic [2:0] ESC_GOT_ESC = 3'd1;
    localparam logic [2:0] ESC_GOT_LB  = 3'd2;
    localparam logic [2:0] ESC_GOT_3   = 3'd3;
    localparam logic [2:0] ESC_GOT_32  = 3'd4;
    localparam logic [2:0] ESC_GOT_0   = 3'd5;

    localparam logic [7:0] CH_ESC       = 8'h1B;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_DIGIT0    = 8'h30;
    localparam logic [7:0] CH_DIGIT2    = 8'h32;
    localparam logic [7:0] CH_DIGIT3    = 8'h33;
    localparam logic [7:0] CH_LOWER_M   = 8'h6D;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;

    localparam logic [tcac_pkg::SUM_W-1:0] SUM_CELLS =
        tcac_pkg::SUM_W'(tcac_pkg::CELL_COUNT);
    localparam logic [tcac_pkg::POS_W-1:0] BOTTOM_ROW =
        tcac_pkg::POS_W'(tcac_pkg::CELL_COUNT - tcac_pkg::COLUMNS);
    localparam logic [tcac_pkg::COL_W-1:0] LAST_COL =
        tcac_pkg::COL_W'(tcac_pkg::COLUMNS - 1);

    logic [2:0]                        r_esc,   n_esc;
    logic [tcac_pkg::ATTR_W-1:0]       r_color, n_color;
    logic [tcac_pkg::POS_W-1:0]        r_pos,   n_pos;
    logic [tcac_pkg::COL_W-1:0]        r_col,   n_col;
    logic [tcac_pkg::POS_W-1:0]        r_limit;
    logic                              consumed;
    logic                              accept;
    logic [tcac_pkg::SUM_W-1:0]        step;
    tcac_pkg::t_cmd                    cmd;

    assign accept     = i_in_valid && !i_full;
    assign o_in_stall = i_full;
    assign o_push     = accept;
    assign o_push_cmd = cmd;

    always_comb begin
        n_esc      = r_esc;
        n_color    = r_color;
        n_pos      = r_pos;
        n_col      = r_col;
        consumed   = 1'b0;
        step       = '0;
        cmd.kind   = tcac_pkg::KIND_NONE;
        cmd.scroll = 1'b0;
        cmd.addr   = r_pos;
        cmd.chr    = tcac_pkg::CH_SPACE;
        case (i_opcode)
            tcac_pkg::OP_PUT: begin
                case (r_esc)
                    ESC_GOT_ESC: begin
                        n_esc = ESC_IDLE;
                        if (i_char_code == CH_LBRACKET) begin
                            n_esc    = ESC_GOT_LB;
                            consumed = 1'b1;
                        end
                    end
                    ESC_GOT_LB: begin
                        n_esc = ESC_IDLE;
                        if (i_char_code == CH_DIGIT3) begin
                            n_esc    = ESC_GOT_3;
                            consumed = 1'b1;
                        end else if (i_char_code == CH_DIGIT0) begin
                            n_esc    = ESC_GOT_0;
                            consumed = 1'b1;
                        end
                    end
                    ESC_GOT_3: begin
                        n_esc = ESC_IDLE;
                        if (i_char_code == CH_DIGIT2) begin
                            n_esc    = ESC_GOT_32;
                            consumed = 1'b1;
                        end
                    end
                    ESC_GOT_32: begin
                        n_esc    = ESC_IDLE;
                        consumed = 1'b1;
                        if (i_char_code == CH_LOWER_M) begin
                            n_color = tcac_pkg::GREEN_ATTR;
                        end
                    end
                    ESC_GOT_0: begin
                        n_esc    = ESC_IDLE;
                        consumed = 1'b1;
                        if (i_char_code == CH_LOWER_M) begin
                            n_color = tcac_pkg::WHITE_ATTR;
                        end
                    end
                    default: begin
                        n_esc = ESC_IDLE;
                        if (i_char_code == CH_ESC) begin
                            n_esc    = ESC_GOT_ESC;
                            consumed = 1'b1;
                        end
                    end
                endcase
                if (!consumed) begin
                    if (i_char_code == CH_NEWLINE) begin
                        // start of current row plus one row
                        step  = {1'b0, r_pos} - tcac_pkg::SUM_W'(r_col)
                              + tcac_pkg::SUM_W'(tcac_pkg::COLUMNS);
                        n_col = '0;
                        if (step >= SUM_CELLS) begin
                            cmd.scroll = 1'b1;
                            n_pos      = BOTTOM_ROW;
                        end else begin
                            n_pos = step[tcac_pkg::POS_W-1:0];
                        end
                    end else if (i_char_code == CH_BACKSPACE) begin
                        if (r_pos > r_limit) begin
                            n_pos    = r_pos - 1'b1;
                            n_col    = (r_col == '0) ? LAST_COL : r_col - 1'b1;
                            cmd.kind = tcac_pkg::KIND_WRITE;
                            cmd.addr = r_pos - 1'b1;
                        end
                    end else begin
                        cmd.kind = tcac_pkg::KIND_WRITE;
                        cmd.chr  = i_char_code;
                        step     = {1'b0, r_pos} + 1'b1;
                        n_col    = (r_col == LAST_COL) ? '0 : r_col + 1'b1;
                        if (step >= SUM_CELLS) begin
                            cmd.scroll = 1'b1;
                            n_pos      = BOTTOM_ROW;
                        end else begin
                            n_pos = step[tcac_pkg::POS_W-1:0];
                        end
                    end
                end
            end
            tcac_pkg::OP_READ: begin
                // out of range reads come back as zero
                if ({1'b0, i_cell_address} < SUM_CELLS) begin
                    cmd.kind = tcac_pkg::KIND_READ;
                    cmd.addr = i_cell_address;
                end
            end
            tcac_pkg::OP_CLEAR: begin
                cmd.kind = tcac_pkg::KIND_CLEAR;
                n_pos    = '0;
                n_col    = '0;
                n_esc    = ESC_IDLE;
            end
            default: begin
            end
        endcase
        cmd.color  = n_color;
        cmd.cursor = n_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc   <= ESC_IDLE;
            r_color <= tcac_pkg::WHITE_ATTR;
            r_pos   <= '0;
            r_col   <= '0;
            r_limit <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
            if (accept) begin
                r_esc   <= n_esc;
                r_color <= n_color;
                r_pos   <= n_pos;
                r_col   <= n_col;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tcac_queue.sv =====
`default_nettype none

module tcac_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire tcac_pkg::t_cmd i_push_cmd,
    input  wire logic           i_pop,
    output tcac_pkg::t_cmd      o_head,
    output logic                o_empty,
    output logic                o_full
);

    tcac_pkg::t_cmd                r_mem [tcac_pkg::QUEUE_DEPTH];
    logic [tcac_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [tcac_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [tcac_pkg::QCNT_W-1:0]   r_count;

    assign o_head  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == tcac_pkg::QCNT_W'(tcac_pkg::QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tcac_back.sv =====
`default_nettype none

module tcac_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire tcac_pkg::t_cmd                i_head,
    input  wire logic                          i_empty,
    output logic                               o_pop,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [tcac_pkg::CHAR_W-1:0]        o_cell_char,
    output logic [tcac_pkg::ATTR_W-1:0]        o_cell_attr,
    output logic [tcac_pkg::POS_W-1:0]         o_cursor_cell,
    output logic [tcac_pkg::ATTR_W-1:0]        o_text_color
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCROLL = 2'd1;
    localparam logic [1:0] S_CLEAR  = 2'd2;
    localparam logic [1:0] S_EMIT   = 2'd3;

    localparam logic [tcac_pkg::SUM_W-1:0] SUM_CELLS =
        tcac_pkg::SUM_W'(tcac_pkg::CELL_COUNT);
    localparam logic [tcac_pkg::POS_W-1:0] LAST_CELL =
        tcac_pkg::POS_W'(tcac_pkg::CELL_COUNT - 1);
    localparam logic [tcac_pkg::POS_W-1:0] LAST_COL =
        tcac_pkg::POS_W'(tcac_pkg::COLUMNS - 1);

    logic [tcac_pkg::CELL_W-1:0]   mem [tcac_pkg::CELL_COUNT];

    logic [1:0]                    r_state, n_state;
    tcac_pkg::t_cmd                r_cur;
    logic [tcac_pkg::POS_W-1:0]    r_base, n_base;
    logic [tcac_pkg::POS_W-1:0]    r_cnt,  n_cnt;
    logic [tcac_pkg::CELL_W-1:0]   r_rdata;
    logic                          r_out_valid;
    logic [tcac_pkg::CHAR_W-1:0]   r_out_char;
    logic [tcac_pkg::ATTR_W-1:0]   r_out_attr;
    logic [tcac_pkg::POS_W-1:0]    r_out_cursor;
    logic [tcac_pkg::ATTR_W-1:0]   r_out_color;

    logic [tcac_pkg::SUM_W-1:0]    head_sum;
    logic [tcac_pkg::SUM_W-1:0]    base_sum;
    logic [tcac_pkg::POS_W-1:0]    phys;
    logic                          we;
    logic                          re;
    logic [tcac_pkg::POS_W-1:0]    waddr;
    logic [tcac_pkg::CELL_W-1:0]   wdata;
    logic                          out_free;
    logic                          emit;

    assign o_pop    = (r_state == S_IDLE) && !i_empty;
    assign out_free = !r_out_valid || !i_out_stall;
    assign emit     = (r_state == S_EMIT) && out_free;

    // screen rows live in a ring: logical cell plus row offset, wrapped
    assign head_sum = {1'b0, i_head.addr} + {1'b0, r_base};
    assign phys     = (head_sum >= SUM_CELLS)
                    ? tcac_pkg::POS_W'(head_sum - SUM_CELLS)
                    : head_sum[tcac_pkg::POS_W-1:0];
    assign base_sum = {1'b0, r_base} + tcac_pkg::SUM_W'(tcac_pkg::COLUMNS);

    always_comb begin
        we      = 1'b0;
        re      = 1'b0;
        waddr   = phys;
        wdata   = {i_head.color, i_head.chr};
        n_state = r_state;
        n_base  = r_base;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    we    = (i_head.kind == tcac_pkg::KIND_WRITE);
                    re    = (i_head.kind == tcac_pkg::KIND_READ);
                    n_cnt = '0;
                    if (i_head.kind == tcac_pkg::KIND_CLEAR) begin
                        n_state = S_CLEAR;
                    end else if (i_head.scroll) begin
                        n_state = S_SCROLL;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_SCROLL: begin
                // the old top row becomes the new bottom row, blanked
                we    = 1'b1;
                waddr = r_base + r_cnt;
                wdata = {r_cur.color, tcac_pkg::CH_SPACE};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_COL) begin
                    n_state = S_EMIT;
                    n_base  = (base_sum >= SUM_CELLS)
                            ? '0 : base_sum[tcac_pkg::POS_W-1:0];
                end
            end
            S_CLEAR: begin
                we    = 1'b1;
                waddr = r_cnt;
                wdata = {r_cur.color, tcac_pkg::CH_SPACE};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_CELL) begin
                    n_state = S_EMIT;
                    n_base  = '0;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            r_rdata <= mem[phys];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_head;
        end
        if (emit) begin
            r_out_char   <= (r_cur.kind == tcac_pkg::KIND_READ)
                          ? r_rdata[tcac_pkg::CHAR_W-1:0] : '0;
            r_out_attr   <= (r_cur.kind == tcac_pkg::KIND_READ)
                          ? r_rdata[tcac_pkg::CELL_W-1:tcac_pkg::CHAR_W] : '0;
            r_out_cursor <= r_cur.cursor;
            r_out_color  <= r_cur.color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_base      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_base  <= n_base;
            r_cnt   <= n_cnt;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_cell_char   = r_out_char;
    assign o_cell_attr   = r_out_attr;
    assign o_cursor_cell = r_out_cursor;
    assign o_text_color  = r_out_color;

endmodule

`default_nettype wire

// ===== hw/rtl/text_console_with_ansi_color_core.sv =====
// channel   direction  handshake                fields
// in        input      i_in_valid / o_in_stall  i_opcode, i_char_code, i_cell_address
// out       output     o_out_valid / i_out_stall o_cell_char, o_cell_attr,
//                                               o_cursor_cell, o_text_color
// cfg       input      i_cfg_wr_en              i_cfg_wr_data (prompt limit)
//
// front parses escapes and moves the cursor, one item per cycle into a 2-entry queue unless it is full
// back finishes each item (one cell memory access, then the output register) before it pops the next
// a scroll blanks one row (one blanked cell per cycle), a clear blanks every cell
// synchronous active-low reset; cell memory is not cleared, no startup pass
// o_in_stall is high while the queue is full; the output register holds under i_out_stall
`default_nettype none

module text_console_with_ansi_color_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [1:0]                    i_opcode,
    input  wire logic [tcac_pkg::CHAR_W-1:0]   i_char_code,
    input  wire logic [tcac_pkg::POS_W-1:0]    i_cell_address,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [tcac_pkg::CHAR_W-1:0]        o_cell_char,
    output logic [tcac_pkg::ATTR_W-1:0]        o_cell_attr,
    output logic [tcac_pkg::POS_W-1:0]         o_cursor_cell,
    output logic [tcac_pkg::ATTR_W-1:0]        o_text_color,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [tcac_pkg::POS_W-1:0]    i_cfg_wr_data
);

    tcac_pkg::t_cmd push_cmd;
    tcac_pkg::t_cmd head;
    logic           push;
    logic           pop;
    logic           q_empty;
    logic           q_full;

    tcac_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_char_code    (i_char_code),
        .i_cell_address (i_cell_address),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_full         (q_full),
        .o_push         (push),
        .o_push_cmd     (push_cmd)
    );

    tcac_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .i_pop      (pop),
        .o_head     (head),
        .o_empty    (q_empty),
        .o_full     (q_full)
    );

    tcac_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .i_empty       (q_empty),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_cell_char   (o_cell_char),
        .o_cell_attr   (o_cell_attr),
        .o_cursor_cell (o_cursor_cell),
        .o_text_color  (o_text_color)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/tcac_checker.sv =====
`default_nettype none

module tcac_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_stall,
    input wire logic [tcac_pkg::CHAR_W-1:0]   o_cell_char,
    input wire logic [tcac_pkg::ATTR_W-1:0]   o_cell_attr,
    input wire logic [tcac_pkg::POS_W-1:0]    o_cursor_cell,
    input wire logic [tcac_pkg::ATTR_W-1:0]   o_text_color
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_cell_char)
            && $stable(o_cell_attr) && $stable(o_cursor_cell) && $stable(o_text_color))
        else $error("result changed while stalled");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_cursor_cell < tcac_pkg::POS_W'(tcac_pkg::CELL_COUNT))
        else $error("cursor beyond last cell");

    a_color_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_text_color == tcac_pkg::GREEN_ATTR
            || o_text_color == tcac_pkg::WHITE_ATTR)
        else $error("text color is neither green nor white");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind text_console_with_ansi_color_core tcac_checker u_tcac_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_cell_char   (o_cell_char),
    .o_cell_attr   (o_cell_attr),
    .o_cursor_cell (o_cursor_cell),
    .o_text_color  (o_text_color)
);

`default_nettype wire
